>>> design/triangle_midpoint_subdivider_top_assert.svh
// Assertion macros shared by the subdivider checker.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_TOP_ASSERT_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define TMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define TMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tms_pkg.sv
// Shared types and constants of the triangle midpoint subdivider.
`timescale 1ns / 1ps
package tms_pkg;

	localparam int MAX_DEPTH_DEF   = 3;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int DEPTH_W         = 2;
	localparam int NUM_AXES        = 3;

	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [1:0]         digit_t;

	localparam depth_t DEPTH_RESET = 2'd3;

	// child codes: corner a, corner b, corner c
	localparam digit_t CHILD_A = 2'd0;
	localparam digit_t CHILD_B = 2'd1;
	localparam digit_t CHILD_C = 2'd2;

	typedef struct packed {
		logic   pass;
		digit_t digit;
	} sel_t;

	typedef struct packed {
		logic vld;
		logic last;
	} ctrl_t;

endpackage

>>> design/tms_level.sv
// One subdivision level of one axis lane: midpoints and child pick, registered.
`timescale 1ns / 1ps
module tms_level #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          adv,
	input  tms_pkg::sel_t                 sel,
	input  logic signed [COORD_WIDTH-1:0] par_a,
	input  logic signed [COORD_WIDTH-1:0] par_b,
	input  logic signed [COORD_WIDTH-1:0] par_c,
	output logic signed [COORD_WIDTH-1:0] child_a,
	output logic signed [COORD_WIDTH-1:0] child_b,
	output logic signed [COORD_WIDTH-1:0] child_c
);
	import tms_pkg::*;

	localparam int W = COORD_WIDTH;

	logic signed [W-1:0] ab, ac, bc;
	logic signed [W-1:0] child_a_q, child_b_q, child_c_q;

	// floor of half the exact sum
	function automatic logic signed [W-1:0] mid(input logic signed [W-1:0] p,
			input logic signed [W-1:0] q);
		logic signed [W:0] s;
		s = {p[W-1], p} + {q[W-1], q};
		return s[W:1];
	endfunction

	assign ab = mid(par_a, par_b);
	assign ac = mid(par_a, par_c);
	assign bc = mid(par_b, par_c);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sel.pass) begin
				child_a_q <= par_a;
				child_b_q <= par_b;
				child_c_q <= par_c;
			end else begin
				case (sel.digit)
					CHILD_A: begin
						child_a_q <= par_a;
						child_b_q <= ab;
						child_c_q <= ac;
					end
					CHILD_B: begin
						child_a_q <= par_b;
						child_b_q <= ab;
						child_c_q <= bc;
					end
					default: begin
						child_a_q <= par_c;
						child_b_q <= ac;
						child_c_q <= bc;
					end
				endcase
			end
		end
	end

	assign child_a = child_a_q;
	assign child_b = child_b_q;
	assign child_c = child_c_q;

endmodule

>>> design/tms_lane.sv
// One coordinate axis lane: a chain of subdivision levels.
`timescale 1ns / 1ps
module tms_lane #(
	parameter int COORD_WIDTH = 16,
	parameter int STAGES      = 3
) (
	input  logic                          clk,
	input  logic                          adv,
	input  tms_pkg::sel_t                 sel [STAGES],
	input  logic signed [COORD_WIDTH-1:0] src_a,
	input  logic signed [COORD_WIDTH-1:0] src_b,
	input  logic signed [COORD_WIDTH-1:0] src_c,
	output logic signed [COORD_WIDTH-1:0] leaf_a,
	output logic signed [COORD_WIDTH-1:0] leaf_b,
	output logic signed [COORD_WIDTH-1:0] leaf_c
);
	import tms_pkg::*;

	logic signed [COORD_WIDTH-1:0] va [STAGES+1];
	logic signed [COORD_WIDTH-1:0] vb [STAGES+1];
	logic signed [COORD_WIDTH-1:0] vc [STAGES+1];

	assign va[0] = src_a;
	assign vb[0] = src_b;
	assign vc[0] = src_c;

	for (genvar l = 0; l < STAGES; l++) begin : g_lvl
		tms_level #(.COORD_WIDTH(COORD_WIDTH)) u_lvl (
			.clk    (clk),
			.adv    (adv),
			.sel    (sel[l]),
			.par_a  (va[l]),
			.par_b  (vb[l]),
			.par_c  (vc[l]),
			.child_a(va[l+1]),
			.child_b(vb[l+1]),
			.child_c(vc[l+1])
		);
	end

	assign leaf_a = va[STAGES];
	assign leaf_b = vb[STAGES];
	assign leaf_c = vc[STAGES];

endmodule

>>> design/triangle_midpoint_subdivider_top.sv
// Top level of the triangle midpoint subdivider.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------------
//   in       | request   | in_valid/in_stall  | vertex_{a,b,c}_{x,y,z}
//   out      | result    | out_valid/out_stall| leaf_{a,b,c}_{x,y,z}, last_leaf
//   cfg      | write     | cfg_we             | cfg_wdata = subdivision_depth
//
// Each request yields 3^d leaves, d = min(subdivision_depth, MAX_DEPTH): one leaf
// leaves the issue counter per cycle unless out_stall holds a result, and the next
// request is taken in the cycle its predecessor issues its last leaf.
// A leaf passes one register per level stage, then the merge register, to out_valid.
// Reset clears control and sets subdivision_depth to 3; coordinates are not reset.
// out_stall on a shown result freezes the whole level pipeline and the issue counter.
`timescale 1ns / 1ps
module triangle_midpoint_subdivider_top #(
	parameter int MAX_DEPTH   = tms_pkg::MAX_DEPTH_DEF,
	parameter int COORD_WIDTH = tms_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  tms_pkg::depth_t               cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
	input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] leaf_a_x,
	output logic signed [COORD_WIDTH-1:0] leaf_a_y,
	output logic signed [COORD_WIDTH-1:0] leaf_a_z,
	output logic signed [COORD_WIDTH-1:0] leaf_b_x,
	output logic signed [COORD_WIDTH-1:0] leaf_b_y,
	output logic signed [COORD_WIDTH-1:0] leaf_b_z,
	output logic signed [COORD_WIDTH-1:0] leaf_c_x,
	output logic signed [COORD_WIDTH-1:0] leaf_c_y,
	output logic signed [COORD_WIDTH-1:0] leaf_c_z,
	output logic                          last_leaf
);
	import tms_pkg::*;

	// at least one level stage, even when no subdivision is allowed
	localparam int NUM_STAGES = (MAX_DEPTH > 0) ? MAX_DEPTH : 1;
	localparam depth_t DEPTH_CAP = DEPTH_W'(MAX_DEPTH);

	// configuration and effective depth
	depth_t depth_q;
	depth_t d_eff;

	// source triangle, one entry per axis
	logic signed [COORD_WIDTH-1:0] src_a_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] src_b_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] src_c_q [NUM_AXES];

	// leaf issue counter: base-3 odometer, deepest level least significant
	logic   issuing_q;
	digit_t digits_q  [NUM_STAGES];
	digit_t digits_nx [NUM_STAGES];
	logic   issue_last;
	sel_t   issue_sel [NUM_STAGES];

	// control travelling alongside the level registers
	ctrl_t ctrl_q [NUM_STAGES];
	sel_t  sel_q  [NUM_STAGES][NUM_STAGES];
	sel_t  lane_sel [NUM_STAGES];

	// lane results and merge register
	logic signed [COORD_WIDTH-1:0] lf_a [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] lf_b [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] lf_c [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] out_a_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] out_b_q [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] out_c_q [NUM_AXES];
	logic out_valid_q;
	logic last_q;

	logic adv;
	logic in_acc;

	// advance the whole pipe unless a finished leaf is held by the consumer
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = issuing_q && !(adv && issue_last);
	assign in_acc   = in_valid && !in_stall;

	assign d_eff = (depth_q > DEPTH_CAP) ? DEPTH_CAP : depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
		end else if (cfg_we) begin
			depth_q <= cfg_wdata;
		end
	end

	// odometer step and last-leaf detect over the active levels only
	always_comb begin
		logic carry;
		carry      = 1'b1;
		issue_last = 1'b1;
		for (int l = NUM_STAGES - 1; l >= 0; l--) begin
			digits_nx[l]       = digits_q[l];
			issue_sel[l].pass  = !(DEPTH_W'(l) < d_eff);
			issue_sel[l].digit = digits_q[l];
			if (DEPTH_W'(l) < d_eff) begin
				if (digits_q[l] != CHILD_C) begin
					issue_last = 1'b0;
				end
				if (carry) begin
					if (digits_q[l] == CHILD_C) begin
						digits_nx[l] = CHILD_A;
					end else begin
						digits_nx[l] = digits_q[l] + 2'd1;
						carry        = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			for (int l = 0; l < NUM_STAGES; l++) begin
				digits_q[l] <= CHILD_A;
			end
		end else if (in_acc) begin
			// a new request restarts the walk at the first corner
			issuing_q <= 1'b1;
			for (int l = 0; l < NUM_STAGES; l++) begin
				digits_q[l] <= CHILD_A;
			end
		end else if (adv && issuing_q) begin
			if (issue_last) begin
				issuing_q <= 1'b0;
			end else begin
				digits_q <= digits_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			src_a_q[0] <= vertex_a_x;
			src_a_q[1] <= vertex_a_y;
			src_a_q[2] <= vertex_a_z;
			src_b_q[0] <= vertex_b_x;
			src_b_q[1] <= vertex_b_y;
			src_b_q[2] <= vertex_b_z;
			src_c_q[0] <= vertex_c_x;
			src_c_q[1] <= vertex_c_y;
			src_c_q[2] <= vertex_c_z;
		end
	end

	// control pipe: valid/last with reset, child selects as payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < NUM_STAGES; l++) begin
				ctrl_q[l] <= '0;
			end
		end else if (adv) begin
			ctrl_q[0] <= '{vld: issuing_q, last: issue_last};
			for (int l = 1; l < NUM_STAGES; l++) begin
				ctrl_q[l] <= ctrl_q[l-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_q[0] <= issue_sel;
			for (int l = 1; l < NUM_STAGES; l++) begin
				sel_q[l] <= sel_q[l-1];
			end
		end
	end

	// each level stage takes the select of the leaf currently entering it
	always_comb begin
		lane_sel[0] = issue_sel[0];
		for (int l = 1; l < NUM_STAGES; l++) begin
			lane_sel[l] = sel_q[l-1][l];
		end
	end

	for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
		tms_lane #(
			.COORD_WIDTH(COORD_WIDTH),
			.STAGES     (NUM_STAGES)
		) u_lane (
			.clk   (clk),
			.adv   (adv),
			.sel   (lane_sel),
			.src_a (src_a_q[ax]),
			.src_b (src_b_q[ax]),
			.src_c (src_c_q[ax]),
			.leaf_a(lf_a[ax]),
			.leaf_b(lf_b[ax]),
			.leaf_c(lf_c[ax])
		);
	end

	// merge: gather the three axis lanes into one leaf result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctrl_q[NUM_STAGES-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctrl_q[NUM_STAGES-1].vld) begin
			out_a_q <= lf_a;
			out_b_q <= lf_b;
			out_c_q <= lf_c;
			last_q  <= ctrl_q[NUM_STAGES-1].last;
		end
	end

	assign out_valid = out_valid_q;
	assign leaf_a_x  = out_a_q[0];
	assign leaf_a_y  = out_a_q[1];
	assign leaf_a_z  = out_a_q[2];
	assign leaf_b_x  = out_b_q[0];
	assign leaf_b_y  = out_b_q[1];
	assign leaf_b_z  = out_b_q[2];
	assign leaf_c_x  = out_c_q[0];
	assign leaf_c_y  = out_c_q[1];
	assign leaf_c_z  = out_c_q[2];
	assign last_leaf = last_q;

endmodule

>>> design/tms_checker.sv
// Port-level checker for the subdivider, bound to the top level.
`timescale 1ns / 1ps
`include "triangle_midpoint_subdivider_top_assert.svh"
module tms_checker #(
	parameter int COORD_WIDTH = tms_pkg::COORD_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [COORD_WIDTH-1:0] leaf_a_x,
	input logic signed [COORD_WIDTH-1:0] leaf_a_y,
	input logic signed [COORD_WIDTH-1:0] leaf_a_z,
	input logic signed [COORD_WIDTH-1:0] leaf_b_x,
	input logic signed [COORD_WIDTH-1:0] leaf_b_y,
	input logic signed [COORD_WIDTH-1:0] leaf_b_z,
	input logic signed [COORD_WIDTH-1:0] leaf_c_x,
	input logic signed [COORD_WIDTH-1:0] leaf_c_y,
	input logic signed [COORD_WIDTH-1:0] leaf_c_z,
	input logic                          last_leaf
);
	import tms_pkg::*;

	logic [9*COORD_WIDTH:0] out_payload;
	logic                   out_acc;

	assign out_payload = {leaf_a_x, leaf_a_y, leaf_a_z, leaf_b_x, leaf_b_y, leaf_b_z,
		leaf_c_x, leaf_c_y, leaf_c_z, last_leaf};
	assign out_acc = out_valid && !out_stall;

	// a held result keeps its valid and its payload
	`TMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload), "stalled result changed")

	// leaves of one request leave back to back: a non-final leaf is followed at once
	`TMS_ASSERT_NEXT(a_leaf_run, out_acc && !last_leaf, out_valid, "gap inside a leaf run")

	// nothing is shown in the first cycle out of reset
	`TMS_ASSERT_NOW(a_rst_quiet, $rose(arst_n), !out_valid, "result right after reset")

endmodule

bind triangle_midpoint_subdivider_top tms_checker #(.COORD_WIDTH(COORD_WIDTH)) u_tms_checker (.*);

>>> sim/triangle_midpoint_subdivider_checker.sv
// Leaf predictor and result checker for the triangle midpoint subdivider.
`timescale 1ns / 1ps
module triangle_midpoint_subdivider_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  tms_pkg::depth_t                     cfg_wdata,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_a_x,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_a_y,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_a_z,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_b_x,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_b_y,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_b_z,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_c_x,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_c_y,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] vertex_c_z,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_a_x,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_a_y,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_a_z,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_b_x,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_b_y,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_b_z,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_c_x,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_c_y,
	input  logic [tms_pkg::COORD_WIDTH_DEF-1:0] leaf_c_z,
	input  logic                                last_leaf,
	output int                                  fail_count,
	output int                                  pending_leaves
);
	import tms_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;

	typedef logic [NUM_AXES-1:0][CW-1:0] vertex_t;
	typedef logic [2:0][NUM_AXES-1:0][CW-1:0] corners_t;   // [vertex][axis]

	typedef struct packed {
		corners_t corners;
		logic     last;
	} leaf_t;

	leaf_t  expected_leaves[$];
	depth_t active_depth;

	// floor((p + q) / 2) on the one-bit-wider sum
	function automatic logic [CW-1:0] halfway(logic [CW-1:0] p, logic [CW-1:0] q);
		logic [CW:0] sum;
		sum = {p[CW-1], p} + {q[CW-1], q};
		return sum[CW:1];
	endfunction

	function automatic vertex_t halfway_vertex(vertex_t p, vertex_t q);
		vertex_t m;
		for (int j = 0; j < NUM_AXES; j++)
			m[j] = halfway(p[j], q[j]);
		return m;
	endfunction

	function automatic corners_t corner_child(corners_t t, digit_t sel);
		vertex_t  ab, ac, bc;
		corners_t child;
		ab = halfway_vertex(t[0], t[1]);
		ac = halfway_vertex(t[0], t[2]);
		bc = halfway_vertex(t[1], t[2]);
		case (sel)
			CHILD_A: begin
				child = {ac, ab, t[0]};
			end
			CHILD_B: begin
				child = {bc, ab, t[1]};
			end
			default: begin
				child = {bc, ac, t[2]};
			end
		endcase
		return child;
	endfunction

	// Queue every leaf of one request, depth-first, level 0 as the top digit.
	function automatic void predict_leaves(corners_t root, depth_t depth);
		int       levels;
		int       count;
		int       rest;
		int       weight;
		corners_t cur;
		leaf_t    leaf;
		levels = (int'(depth) > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(depth);
		count = 1;
		for (int l = 0; l < levels; l++)
			count *= 3;
		for (int k = 0; k < count; k++) begin
			cur = root;
			rest = k;
			weight = count;
			for (int l = 0; l < levels; l++) begin
				weight = weight / 3;
				cur = corner_child(cur, digit_t'(rest / weight));
				rest = rest % weight;
			end
			leaf.corners = cur;
			leaf.last = (k == count - 1);
			expected_leaves.push_back(leaf);
		end
	endfunction

	function automatic int count_mismatches(leaf_t want, leaf_t got);
		string vnames[3];
		string anames[3];
		int    errs;
		vnames = '{"a", "b", "c"};
		anames = '{"x", "y", "z"};
		errs = 0;
		for (int v = 0; v < 3; v++) begin
			for (int j = 0; j < NUM_AXES; j++) begin
				if (got.corners[v][j] !== want.corners[v][j]) begin
					$error("leaf_%s_%s: expected %0d, actual %0d", vnames[v], anames[j],
						$signed(want.corners[v][j]), $signed(got.corners[v][j]));
					errs++;
				end
			end
		end
		if (got.last !== want.last) begin
			$error("last_leaf: expected %0d, actual %0d", want.last, got.last);
			errs++;
		end
		return errs;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		leaf_t    got;
		corners_t root;
		if (!arst_n) begin
			expected_leaves.delete();
			active_depth <= DEPTH_RESET;
			fail_count <= 0;
			pending_leaves <= 0;
		end else begin
			// retire the result first: it never belongs to a request taken this edge
			if (out_valid && !out_stall) begin
				got.corners = {leaf_c_z, leaf_c_y, leaf_c_x, leaf_b_z, leaf_b_y, leaf_b_x,
					leaf_a_z, leaf_a_y, leaf_a_x};
				got.last = last_leaf;
				if (expected_leaves.size() == 0) begin
					$error("leaf with no expectation: leaf_a_x %0d, last_leaf %0d",
						$signed(leaf_a_x), last_leaf);
					fail_count <= fail_count + 1;
				end else begin
					fail_count <= fail_count +
						count_mismatches(expected_leaves.pop_front(), got);
				end
			end
			if (in_valid && !in_stall) begin
				root = {vertex_c_z, vertex_c_y, vertex_c_x, vertex_b_z, vertex_b_y, vertex_b_x,
					vertex_a_z, vertex_a_y, vertex_a_x};
				predict_leaves(root, active_depth);
			end
			if (cfg_we)
				active_depth <= cfg_wdata;
			pending_leaves <= expected_leaves.size();
		end
	end

endmodule

>>> sim/tb_triangle_midpoint_subdivider_top.sv
// Testbench top for the triangle midpoint subdivider: stimulus, stall pattern and verdict.
`timescale 1ns / 1ps
module tb_triangle_midpoint_subdivider_top;
	import tms_pkg::*;

	localparam int CW           = COORD_WIDTH_DEF;
	localparam int PERIOD       = 8;
	localparam int RESET_CYCLES = 12;
	// drain wait: room for a leaf to pass the level stages and the merge register
	localparam int DRAIN_CYCLES = MAX_DEPTH_DEF + 1 + 4;
	// worst case: ~150 requests x 27 leaves each, stretched by receiver stalls
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 15;

	typedef logic [NUM_AXES-1:0][CW-1:0] vertex_t;
	typedef logic [2:0][NUM_AXES-1:0][CW-1:0] triangle_t;   // [vertex][axis]

	localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] COORD_M1  = {CW{1'b1}};

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            cfg_we = 1'b0;
	depth_t          cfg_wdata = '0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [CW-1:0]   vertex_a_x = '0, vertex_a_y = '0, vertex_a_z = '0;
	logic [CW-1:0]   vertex_b_x = '0, vertex_b_y = '0, vertex_b_z = '0;
	logic [CW-1:0]   vertex_c_x = '0, vertex_c_y = '0, vertex_c_z = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [CW-1:0]   leaf_a_x, leaf_a_y, leaf_a_z;
	logic [CW-1:0]   leaf_b_x, leaf_b_y, leaf_b_z;
	logic [CW-1:0]   leaf_c_x, leaf_c_y, leaf_c_z;
	logic            last_leaf;
	int              fail_count;
	int              pending_leaves;
	int              cycle_count = 0;

	// receiver stall pattern state
	int              stall_mode = 0;
	int              stall_run = 0;
	int unsigned     stall_tick = 0;

	always #(PERIOD / 2) clk = ~clk;

	triangle_midpoint_subdivider_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.vertex_a_x (vertex_a_x),
		.vertex_a_y (vertex_a_y),
		.vertex_a_z (vertex_a_z),
		.vertex_b_x (vertex_b_x),
		.vertex_b_y (vertex_b_y),
		.vertex_b_z (vertex_b_z),
		.vertex_c_x (vertex_c_x),
		.vertex_c_y (vertex_c_y),
		.vertex_c_z (vertex_c_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.leaf_a_x   (leaf_a_x),
		.leaf_a_y   (leaf_a_y),
		.leaf_a_z   (leaf_a_z),
		.leaf_b_x   (leaf_b_x),
		.leaf_b_y   (leaf_b_y),
		.leaf_b_z   (leaf_b_z),
		.leaf_c_x   (leaf_c_x),
		.leaf_c_y   (leaf_c_y),
		.leaf_c_z   (leaf_c_z),
		.last_leaf  (last_leaf)
	);

	// The checker sees the same pins as the block and owns all prediction.
	triangle_midpoint_subdivider_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.vertex_a_x     (vertex_a_x),
		.vertex_a_y     (vertex_a_y),
		.vertex_a_z     (vertex_a_z),
		.vertex_b_x     (vertex_b_x),
		.vertex_b_y     (vertex_b_y),
		.vertex_b_z     (vertex_b_z),
		.vertex_c_x     (vertex_c_x),
		.vertex_c_y     (vertex_c_y),
		.vertex_c_z     (vertex_c_z),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.leaf_a_x       (leaf_a_x),
		.leaf_a_y       (leaf_a_y),
		.leaf_a_z       (leaf_a_z),
		.leaf_b_x       (leaf_b_x),
		.leaf_b_y       (leaf_b_y),
		.leaf_b_z       (leaf_b_z),
		.leaf_c_x       (leaf_c_x),
		.leaf_c_y       (leaf_c_y),
		.leaf_c_z       (leaf_c_z),
		.last_leaf      (last_leaf),
		.fail_count     (fail_count),
		.pending_leaves (pending_leaves)
	);

	// Watchdog: a hung handshake or a leaf that never comes ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL triangle_midpoint_subdivider_top");
			$finish;
		end
	end

	// Receiver stall pattern. Pick a new mode at regular stall_tick intervals:
	//   0 - never stall (back-to-back leaves)
	//   1 - stall with a probability of one in four
	//   2 - toggle between stall and flow in runs of random length
	//   3 - alternate stall and flow, following stall_tick[0]
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 128 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				if (stall_run == 0) begin
					out_stall <= ~out_stall;
					stall_run <= $urandom_range(1, 10);
				end else begin
					stall_run <= stall_run - 1;
				end
			end
			default: begin
				out_stall <= stall_tick[0];
			end
		endcase
	end

	function automatic vertex_t vtx(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		return {z, y, x};
	endfunction

	function automatic triangle_t make_triangle(vertex_t a, vertex_t b, vertex_t c);
		return {c, b, a};
	endfunction

	// Mix the rails, values around zero and full-range noise so that
	// midpoint sums hit both signs, odd negatives and every bit.
	function automatic logic [CW-1:0] rand_coord();
		logic [CW-1:0] c;
		case ($urandom_range(0, 7))
			0: c = COORD_MIN;
			1: c = COORD_MAX;
			2: c = CW'($urandom_range(0, 15)) - CW'(8);
			default: c = CW'($urandom);
		endcase
		return c;
	endfunction

	function automatic triangle_t rand_triangle();
		triangle_t t;
		for (int v = 0; v < 3; v++)
			for (int j = 0; j < NUM_AXES; j++)
				t[v][j] = rand_coord();
		// now and then collapse two corners onto one point
		if ($urandom_range(0, 9) == 0)
			t[1] = t[0];
		return t;
	endfunction

	// Present one request and hold it until the block takes it, then idle for
	// the given gap. With gap 0 valid stays high for the next request.
	task automatic send_triangle(input triangle_t t, input int gap);
		in_valid <= 1'b1;
		vertex_a_x <= t[0][0];
		vertex_a_y <= t[0][1];
		vertex_a_z <= t[0][2];
		vertex_b_x <= t[1][0];
		vertex_b_y <= t[1][1];
		vertex_b_z <= t[1][2];
		vertex_c_x <= t[2][0];
		vertex_c_y <= t[2][1];
		vertex_c_z <= t[2][2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every predicted leaf, then let the pipeline settle.
	// The extra edge first lets the checker's count include the last request.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_leaves != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the depth register; only called with the block idle.
	task automatic set_depth(input depth_t depth);
		cfg_wdata <= depth;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		int gap;
		int burst_left;
		depth_t depth;

		// hold reset for a fixed count, then release on a clock edge
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset depth of 3: both rails, mixed rails with odd
		// negative sums, and the +/-1 cases where the floor rounds down.
		send_triangle(make_triangle(vtx(COORD_MIN, COORD_MIN, COORD_MIN),
			vtx(COORD_MIN, COORD_MIN, COORD_MIN), vtx(COORD_MIN, COORD_MIN, COORD_MIN)), 0);
		send_triangle(make_triangle(vtx(COORD_MAX, COORD_MAX, COORD_MAX),
			vtx(COORD_MAX, COORD_MAX, COORD_MAX), vtx(COORD_MAX, COORD_MAX, COORD_MAX)), 3);
		send_triangle(make_triangle(vtx(COORD_MAX, COORD_MIN, '0),
			vtx(COORD_MIN, COORD_MAX, COORD_M1), vtx('0, COORD_M1, COORD_MAX)), 0);
		send_triangle(make_triangle(vtx(COORD_M1, CW'(1), '0),
			vtx('0, COORD_M1, CW'(1)), vtx(CW'(1), '0, COORD_M1)), 0);
		drain();

		// Depth zero: the request comes back as its own single leaf.
		set_depth(depth_t'(0));
		send_triangle(make_triangle(vtx(COORD_MIN, COORD_MAX, '0),
			vtx(COORD_MAX, '0, COORD_MIN), vtx('0, COORD_MIN, COORD_MAX)), 0);
		send_triangle(make_triangle(vtx(CW'('hAAAA), CW'('h5555), CW'('hAAAA)),
			vtx(CW'('h5555), CW'('hAAAA), CW'('h5555)),
			vtx(COORD_M1, COORD_M1, COORD_M1)), 0);
		send_triangle(rand_triangle(), 2);
		send_triangle(rand_triangle(), 0);
		drain();

		// Depth one: three corner leaves, odd negative sums.
		set_depth(depth_t'(1));
		send_triangle(make_triangle(vtx(COORD_MAX, COORD_MAX, COORD_MAX),
			vtx(COORD_MIN, COORD_MIN, COORD_MIN), vtx(COORD_MIN, COORD_MAX, COORD_MIN)), 0);
		send_triangle(make_triangle(vtx(-CW'(3), -CW'(5), -CW'(7)),
			vtx(CW'(2), CW'(4), CW'(6)), vtx(-CW'(1), CW'(1), -CW'(2))), 0);
		send_triangle(rand_triangle(), 1);
		drain();

		// Depth two.
		set_depth(depth_t'(2));
		send_triangle(make_triangle(vtx(COORD_MIN, '0, COORD_MAX),
			vtx(COORD_MAX, COORD_MIN, '0), vtx('0, COORD_MAX, COORD_MIN)), 0);
		send_triangle(rand_triangle(), 5);
		send_triangle(rand_triangle(), 0);
		drain();

		// Depth three, written explicitly this time.
		set_depth(depth_t'(3));
		send_triangle(rand_triangle(), 0);
		send_triangle(rand_triangle(), 0);
		drain();

		// Random phases: sweep every depth first, then random ones. The sender
		// runs bursts of 1..8 requests with a random idle gap between them.
		for (int phase = 0; phase < PHASES; phase++) begin
			depth = (phase < 4) ? depth_t'(3 - phase) : depth_t'($urandom_range(0, 3));
			set_depth(depth);
			burst_left = $urandom_range(1, 8);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				burst_left--;
				if (burst_left == 0) begin
					gap = $urandom_range(1, 12);
					burst_left = $urandom_range(1, 8);
				end else begin
					gap = 0;
				end
				send_triangle(rand_triangle(), gap);
			end
			drain();
		end

		// drain() above already waited out the pipeline after the last leaf
		if (fail_count == 0)
			$display("PASS triangle_midpoint_subdivider_top");
		else
			$display("FAIL triangle_midpoint_subdivider_top");
		$finish;
	end

endmodule

>>> triangle_midpoint_subdivider_top.f
+incdir+design
design/tms_pkg.sv
design/tms_level.sv
design/tms_lane.sv
design/triangle_midpoint_subdivider_top.sv
design/tms_checker.sv
sim/triangle_midpoint_subdivider_checker.sv
sim/tb_triangle_midpoint_subdivider_top.sv
